/* rtl/multi_sensor_thermostat_band_unit_macros.svh */
// Assertion macros shared by the thermostat band unit.
`ifndef MULTI_SENSOR_THERMOSTAT_BAND_UNIT_MACROS_SVH
`define MULTI_SENSOR_THERMOSTAT_BAND_UNIT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define MSTB_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define MSTB_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mstb_pkg.sv */
// Package with types, constants and scaling factors of the thermostat band unit.
package mstb_pkg;

  // Field widths.
  localparam int NumLanes = 4;
  localparam int ReadW    = 10;
  localparam int TempW    = 10;
  localparam int AvgW     = 17;
  localparam int SetW     = 7;
  localparam int CntW     = 3;
  localparam int SumW     = 12;
  localparam int NumW     = 20;
  localparam int Q5W      = 18;
  localparam int QW       = 16;
  localparam int ScaleW   = 12;
  localparam int BandW    = SetW + ScaleW;

  // Parameter defaults.
  localparam int DefNumSensors = 4;
  localparam int DefAdcBits    = 10;

  // Per-sensor scaling: floor(r * 0.488) = (r * TempMul) >> TempShift.
  localparam int TempMulW  = 22;
  localparam logic [TempMulW-1:0] TempMul = 22'd4093649;
  localparam int TempShift = 23;

  // Average scaling: floor(sum * 244 / 5) = (sum * Div5Mul) >> Div5Shift.
  localparam int Div5MulW  = 28;
  localparam logic [Div5MulW-1:0] Div5Mul = 28'd204682084;
  localparam int Div5Shift = 22;

  // Division by three: (x * Div3Mul) >> Div3Shift.
  localparam int Div3MulW  = 18;
  localparam logic [Div3MulW-1:0] Div3Mul = 18'd174763;
  localparam int Div3Shift = 19;

  // Sum to hundredths of a degree times five per sensor.
  localparam logic [7:0] SumScale = 8'd244;

  // Degrees and setpoint limits.
  localparam logic [SetW-1:0] OffsetDeg = 7'd12;
  localparam logic [SetW-1:0] SetTop    = 7'd99;
  localparam logic [SetW-1:0] MinReset  = 7'd30;
  localparam logic [SetW-1:0] MaxReset  = 7'd40;
  localparam logic signed [AvgW-1:0] OffsetCenti = 17'sd1200;

  typedef enum logic [1:0] {EV_TICK, EV_MODE, EV_DOWN, EV_UP} evt_e;
  typedef enum logic [1:0] {SCR_RUN, SCR_MIN, SCR_MAX, SCR_SENSORS} screen_e;
  typedef enum logic [2:0] {ST_IDLE, ST_LANE, ST_SUM, ST_DIV, ST_DONE} state_e;

  // What one sensor lane found.
  typedef struct packed {
    logic                    counted;
    logic [ReadW-1:0]        reading;
    logic signed [TempW-1:0] temp;
  } lane_t;

  // Stage loads for the merging unit.
  typedef struct packed {
    logic sum_en;
    logic div_en;
  } merge_ctrl_t;

  // Result of the merging unit.
  typedef struct packed {
    logic                   none;
    logic                   below;
    logic                   above;
    logic signed [AvgW-1:0] avg;
  } merge_res_t;

endpackage

/* rtl/mstb_lane.sv */
// One sensor lane: masks the reading, flags it for the average and scales it to degrees.
module mstb_lane import mstb_pkg::*; #(
  parameter int ADC_BITS = DefAdcBits,
  parameter bit LANE_ON  = 1'b1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [ReadW-1:0] reading_i,
  output lane_t            lane_o
);

  localparam int MaskBits = (ADC_BITS < ReadW) ? ADC_BITS : ReadW;
  localparam logic [ReadW-1:0] ReadMask = {ReadW{1'b1}} >> (ReadW - MaskBits);
  localparam int TProdW = ReadW + TempMulW;

  logic [ReadW-1:0]  read_m;
  logic [TProdW-1:0] prod;
  lane_t             lane_d, lane_q;

  // Reading times 0.488, truncated, less the offset.
  always_comb begin
    read_m         = reading_i & ReadMask;
    prod           = TProdW'(read_m) * TProdW'(TempMul);
    lane_d.counted = LANE_ON && (read_m != '0);
    lane_d.reading = read_m;
    lane_d.temp    = $signed({1'b0, prod[TProdW-1:TempShift]}) -
                     $signed(TempW'(OffsetDeg));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

/* rtl/mstb_merge.sv */
// Merging stage: sums the counted lanes, divides by the count and tests the setpoint band.
module mstb_merge import mstb_pkg::*; (
  input  logic            clk_i,
  input  merge_ctrl_t     ctrl_i,
  input  lane_t           lanes_i [NumLanes],
  input  logic [SetW-1:0] min_i,
  input  logic [SetW-1:0] max_i,
  output merge_res_t      res_o
);

  localparam int P5W = SumW + Div5MulW;
  localparam int P3W = Q5W + Div3MulW;

  logic [SumW-1:0]  sum_d, sum_q;
  logic [CntW-1:0]  cnt_d, cnt_q, cnt2_q;
  logic [P5W-1:0]   prod5;
  logic [Q5W-1:0]   q5_q;
  logic [NumW-1:0]  num_q;
  logic [BandW-1:0] lo_q, hi_q;
  logic [ScaleW-1:0] scale;
  logic [P3W-1:0]   prod3;
  logic [QW-1:0]    quot;

  // Five hundred per counted sensor: the band edges in the same units as the sum.
  function automatic logic [ScaleW-1:0] band_scale(input logic [CntW-1:0] c);
    logic [ScaleW-1:0] s;
    case (c)
      3'd1:    s = 12'd500;
      3'd2:    s = 12'd1000;
      3'd3:    s = 12'd1500;
      3'd4:    s = 12'd2000;
      3'd5:    s = 12'd2500;
      3'd6:    s = 12'd3000;
      3'd7:    s = 12'd3500;
      default: s = 12'd0;
    endcase
    return s;
  endfunction

  // Sum and count of the lanes that carry a reading.
  always_comb begin
    sum_d = '0;
    cnt_d = '0;
    for (int i = 0; i < NumLanes; i++) begin
      if (lanes_i[i].counted) begin
        sum_d = sum_d + SumW'(lanes_i[i].reading);
        cnt_d = cnt_d + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  // Scaled sum, its fifth, and the band edges times the count.
  always_comb begin
    prod5 = P5W'(sum_q) * P5W'(Div5Mul);
    scale = band_scale(cnt_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_en) begin
      q5_q   <= prod5[Div5Shift +: Q5W];
      num_q  <= NumW'(sum_q) * NumW'(SumScale);
      lo_q   <= BandW'(min_i + OffsetDeg) * BandW'(scale);
      hi_q   <= BandW'(max_i + OffsetDeg) * BandW'(scale);
      cnt2_q <= cnt_q;
    end
  end

  // Division by the count: shifts for one, two and four, a reciprocal for three.
  always_comb begin
    prod3 = P3W'(q5_q) * P3W'(Div3Mul);
    case (cnt2_q)
      3'd2:    quot = QW'(q5_q >> 1);
      3'd3:    quot = prod3[Div3Shift +: QW];
      3'd4:    quot = QW'(q5_q >> 2);
      default: quot = q5_q[QW-1:0];
    endcase
  end

  // The compare is made on the exact scaled sum, not on the truncated average.
  always_comb begin
    res_o.none  = (cnt2_q == '0);
    res_o.below = (num_q < NumW'(lo_q));
    res_o.above = (num_q > NumW'(hi_q));
    res_o.avg   = res_o.none ? '0 : ($signed({1'b0, quot}) - OffsetCenti);
  end

endmodule

/* rtl/multi_sensor_thermostat_band_unit.sv */
// Top level of the thermostat band unit: sequencer, lanes, merging stage and result register.
//
// Usage. Each input transfer carries one event on mode_i (sample tick, mode,
// down or up button) and four converter readings. Each event gives exactly one
// result transfer on the output channel with the load drives, the average in
// hundredths of a degree, the screen, both setpoints and the per-sensor temps.
// A result passes the sensor lanes, the lane sum, the scaling multipliers and
// the count division with the band compare before it is loaded into the
// output register. One item is in work at a time, so input ready stays low
// from an input transfer until the sequencer is back in idle, and no new item
// is taken before the last one is through; the sequencer sets that.
// The result sits in an output register, so the next input transfer is taken
// while a result still waits. If the receiver stalls, the finished item waits
// in the last step until the register frees up, and input ready stays low.
// Reset puts the run screen on, the setpoints at 30 and 40 degrees, both loads
// off, and the output channel empty.
`include "multi_sensor_thermostat_band_unit_macros.svh"

module multi_sensor_thermostat_band_unit import mstb_pkg::*; #(
  parameter int NUM_SENSORS = DefNumSensors,
  parameter int ADC_BITS    = DefAdcBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              mode_i,
  input  logic [ReadW-1:0]        sensor_a_i,
  input  logic [ReadW-1:0]        sensor_b_i,
  input  logic [ReadW-1:0]        sensor_c_i,
  input  logic [ReadW-1:0]        sensor_d_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    heater_on_o,
  output logic                    cooler_on_o,
  output logic signed [AvgW-1:0]  avg_temp_centi_o,
  output logic                    no_reading_o,
  output logic [1:0]              screen_mode_o,
  output logic [SetW-1:0]         low_setpoint_o,
  output logic [SetW-1:0]         high_setpoint_o,
  output logic signed [TempW-1:0] temp_a_o,
  output logic signed [TempW-1:0] temp_b_o,
  output logic signed [TempW-1:0] temp_c_o,
  output logic signed [TempW-1:0] temp_d_o
);

  state_e      state_q, state_d;
  evt_e        evt_q;
  logic [ReadW-1:0] sens_q [NumLanes];
  lane_t       lanes [NumLanes];
  merge_ctrl_t mctrl;
  merge_res_t  mres;
  logic        accept, lane_en, commit;

  screen_e         screen_q, screen_d;
  logic [SetW-1:0] min_q, min_d, max_q, max_d;
  logic            heat_q, heat_d, cool_q, cool_d;
  logic            out_valid_q, out_valid_d;
  logic signed [AvgW-1:0]  avg_q, avg_d;
  logic                    nr_q, nr_d;
  logic signed [TempW-1:0] temp_q [NumLanes];
  logic signed [TempW-1:0] temp_d [NumLanes];

  assign accept = in_valid_i && in_ready_o;

  // Input capture on transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      evt_q     <= evt_e'(mode_i);
      sens_q[0] <= sensor_a_i;
      sens_q[1] <= sensor_b_i;
      sens_q[2] <= sensor_c_i;
      sens_q[3] <= sensor_d_i;
    end
  end

  // Sensor lanes side by side.
  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    mstb_lane #(
      .ADC_BITS (ADC_BITS),
      .LANE_ON  (g < NUM_SENSORS)
    ) u_lane (
      .clk_i     (clk_i),
      .en_i      (lane_en),
      .reading_i (sens_q[g]),
      .lane_o    (lanes[g])
    );
  end

  mstb_merge u_merge (
    .clk_i   (clk_i),
    .ctrl_i  (mctrl),
    .lanes_i (lanes),
    .min_i   (min_q),
    .max_i   (max_q),
    .res_o   (mres)
  );

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_LANE;
      ST_LANE: state_d = ST_SUM;
      ST_SUM:  state_d = ST_DIV;
      ST_DIV:  state_d = ST_DONE;
      ST_DONE: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o   = 1'b0;
    lane_en      = 1'b0;
    mctrl.sum_en = 1'b0;
    mctrl.div_en = 1'b0;
    commit       = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o   = 1'b1;
      ST_LANE: lane_en      = 1'b1;
      ST_SUM:  mctrl.sum_en = 1'b1;
      ST_DIV:  mctrl.div_en = 1'b1;
      ST_DONE: commit       = !out_valid_q || out_ready_i;
      default: commit       = 1'b0;
    endcase
  end

  // Event handling and the result fields, applied when the result is loaded.
  always_comb begin
    screen_d = screen_q;
    min_d    = min_q;
    max_d    = max_q;
    heat_d   = heat_q;
    cool_d   = cool_q;
    avg_d    = '0;
    nr_d     = 1'b0;
    for (int i = 0; i < NumLanes; i++) begin
      temp_d[i] = '0;
    end
    case (evt_q)
      EV_TICK: begin
        avg_d = mres.avg;
        nr_d  = mres.none;
        for (int i = 0; i < NumLanes; i++) begin
          temp_d[i] = lanes[i].temp;
        end
        if (screen_q == SCR_RUN) begin
          heat_d = !mres.none && mres.below;
          cool_d = !mres.none && !mres.below && mres.above;
        end
      end
      EV_MODE: begin
        screen_d = screen_e'(2'(screen_q + 2'd1));
      end
      EV_DOWN: begin
        if (screen_q == SCR_MIN && min_q != '0) begin
          min_d = min_q - SetW'(1);
        end else if (screen_q == SCR_MAX && max_q != '0) begin
          max_d = max_q - SetW'(1);
        end
      end
      EV_UP: begin
        if (screen_q == SCR_MIN && min_q < SetTop) begin
          min_d = min_q + SetW'(1);
        end else if (screen_q == SCR_MAX && max_q < SetTop) begin
          max_d = max_q + SetW'(1);
        end
      end
      default: begin
        screen_d = screen_q;
      end
    endcase
  end

  // Output channel valid.
  always_comb begin
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control and thermostat state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      screen_q    <= SCR_RUN;
      min_q       <= MinReset;
      max_q       <= MaxReset;
      heat_q      <= 1'b0;
      cool_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        screen_q <= screen_d;
        min_q    <= min_d;
        max_q    <= max_d;
        heat_q   <= heat_d;
        cool_q   <= cool_d;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (commit) begin
      avg_q  <= avg_d;
      nr_q   <= nr_d;
      temp_q <= temp_d;
    end
  end

  // The drives, screen and setpoints change only when a result is loaded,
  // so they stand for the result that waits.
  assign out_valid_o      = out_valid_q;
  assign heater_on_o      = heat_q;
  assign cooler_on_o      = cool_q;
  assign avg_temp_centi_o = avg_q;
  assign no_reading_o     = nr_q;
  assign screen_mode_o    = screen_q;
  assign low_setpoint_o   = min_q;
  assign high_setpoint_o  = max_q;
  assign temp_a_o         = temp_q[0];
  assign temp_b_o         = temp_q[1];
  assign temp_c_o         = temp_q[2];
  assign temp_d_o         = temp_q[3];

  // Checks.
  `MSTB_CHECK(a_drive_excl, !(heat_q && cool_q), "heater and cooler both on")
  `MSTB_CHECK(a_set_range, (min_q <= SetTop) && (max_q <= SetTop), "setpoint above top")
  `MSTB_CHECK(a_nr_avg, !(out_valid_q && nr_q) || (avg_q == '0), "average set with no reading")
  `MSTB_NEXT(a_accept_seq, accept, state_q == ST_LANE, "transfer did not start the lanes")

endmodule
